@@ sv/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, command and status codes, and sequencer states for the
// positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_START,
    ST_WALK,
    ST_INS_FIX,
    ST_INS_LINK,
    ST_DEL_P1,
    ST_DEL_Q,
    ST_DEL_FIX,
    ST_DEL_FREE,
    ST_READ,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

@@ sv/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values kept as a linked list in an element RAM and a
// link RAM, with insert, delete, read at position, locate and clear.
// ----------------------------------------------------------------------------
// One word in flight at a time; one link RAM read per list hop.
// Insert at p = 1 links in a new head; other inserts, delete and read at p walk
// from the head, locate scans to a match or the end, and clear and errors finish.
// The result register lets the next word in while a result waits.
// Synchronous reset empties the list at once; no RAM clearing pass, new slots
// come from a high-water mark and freed slots from a free chain.
module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ple_pkg::CMD_W-1:0]           in_cmd,
  input  logic [ple_pkg::POS_W-1:0]           in_position,
  input  logic signed [ple_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ple_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ple_pkg::VALUE_W-1:0]  out_result_value,
  output logic [ple_pkg::POS_W-1:0]           out_found_position,
  output logic [ple_pkg::POS_W-1:0]           out_list_length,
  output logic                                out_is_empty
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PCW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
  localparam int DW  = DATA_WIDTH;
  localparam int PW  = ple_pkg::POS_W;
  localparam int VW  = ple_pkg::VALUE_W;

  ple_pkg::state_t state_r, state_nxt;

  logic [ple_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [DW-1:0]                val_r, val_nxt;
  logic [IW-1:0]                head_r, head_nxt;
  logic [IW-1:0]                fhead_r, fhead_nxt;
  logic [CW-1:0]                wm_r, wm_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [IW-1:0]                node_r, node_nxt;
  logic                         src_mem_r, src_mem_nxt;
  logic [PW-1:0]                steps_r, steps_nxt;
  logic [CW-1:0]                scan_r, scan_nxt;
  logic [IW-1:0]                slot_r, slot_nxt;
  logic                         pop_r, pop_nxt;
  logic [ple_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [DW-1:0]                rval_r, rval_nxt;
  logic [CW-1:0]                found_r, found_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [ple_pkg::STATUS_W-1:0] out_status_r;
  logic [VW-1:0]                out_rval_r;
  logic [PW-1:0]                out_found_r;
  logic [PW-1:0]                out_len_r;
  logic                         out_empty_r;

  logic          link_we, link_re;
  logic [IW-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
  logic          elem_we, elem_re;
  logic [IW-1:0] elem_waddr, elem_raddr;
  logic [DW-1:0] elem_wdata, elem_rdata;

  logic [DW+VW-1:0] vext;
  logic [DW-1:0]    in_val_dw;
  logic [PCW-1:0]   pos_x, cnt_x;
  logic             ins_bad, pos_bad, full, pos_one, walk_done, scan_hit, scan_end;
  logic             out_free, fin_load;
  logic [IW-1:0]    cur;
  logic [CW-1:0]    one_c;
  logic [VW+DW-1:0] rext;
  logic [CW+PW-1:0] cext, fext;

  assign vext      = {{DW{1'b0}}, in_value};
  assign in_val_dw = vext[DW-1:0];
  assign pos_x     = {{(PCW-PW){1'b0}}, in_position};
  assign cnt_x     = {{(PCW-CW){1'b0}}, count_r};
  assign one_c     = {{(CW-1){1'b0}}, 1'b1};
  assign ins_bad   = (in_position == '0) || (pos_x > cnt_x + {{(PCW-1){1'b0}}, 1'b1});
  assign pos_bad   = (in_position == '0) || (pos_x > cnt_x);
  assign full      = cnt_x >= PCW'(CAPACITY);
  assign pos_one   = pos_r == {{(PW-1){1'b0}}, 1'b1};
  assign cur       = src_mem_r ? link_rdata : node_r;
  assign walk_done = steps_r == '0;
  assign scan_hit  = src_mem_r && (elem_rdata == val_r);
  assign scan_end  = scan_r == count_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_load  = (state_r == ple_pkg::ST_FIN) && out_free;

  ple_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  ple_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .re    (elem_re),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ple_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            ple_pkg::CMD_INSERT: begin
              state_nxt = (ins_bad || full) ? ple_pkg::ST_FIN : ple_pkg::ST_INS_START;
            end
            ple_pkg::CMD_DELETE, ple_pkg::CMD_READ: begin
              state_nxt = pos_bad ? ple_pkg::ST_FIN : ple_pkg::ST_WALK;
            end
            ple_pkg::CMD_LOCATE: state_nxt = ple_pkg::ST_SCAN;
            default:             state_nxt = ple_pkg::ST_FIN;
          endcase
        end
      end
      ple_pkg::ST_INS_START: state_nxt = pos_one ? ple_pkg::ST_FIN : ple_pkg::ST_WALK;
      ple_pkg::ST_WALK: begin
        if (walk_done) begin
          case (cmd_r)
            ple_pkg::CMD_INSERT: state_nxt = ple_pkg::ST_INS_FIX;
            ple_pkg::CMD_DELETE: state_nxt = pos_one ? ple_pkg::ST_DEL_P1 : ple_pkg::ST_DEL_Q;
            default:             state_nxt = ple_pkg::ST_READ;
          endcase
        end
      end
      ple_pkg::ST_INS_FIX:  state_nxt = ple_pkg::ST_INS_LINK;
      ple_pkg::ST_INS_LINK: state_nxt = ple_pkg::ST_FIN;
      ple_pkg::ST_DEL_P1:   state_nxt = ple_pkg::ST_DEL_FREE;
      ple_pkg::ST_DEL_Q:    state_nxt = ple_pkg::ST_DEL_FIX;
      ple_pkg::ST_DEL_FIX:  state_nxt = ple_pkg::ST_DEL_FREE;
      ple_pkg::ST_DEL_FREE: state_nxt = ple_pkg::ST_FIN;
      ple_pkg::ST_READ:     state_nxt = ple_pkg::ST_FIN;
      ple_pkg::ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = ple_pkg::ST_FIN;
        end
      end
      ple_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = ple_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ple_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    cmd_nxt     = cmd_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    head_nxt    = head_r;
    fhead_nxt   = fhead_r;
    wm_nxt      = wm_r;
    count_nxt   = count_r;
    node_nxt    = node_r;
    src_mem_nxt = src_mem_r;
    steps_nxt   = steps_r;
    scan_nxt    = scan_r;
    slot_nxt    = slot_r;
    pop_nxt     = pop_r;
    status_nxt  = status_r;
    rval_nxt    = rval_r;
    found_nxt   = found_r;
    link_we     = 1'b0;
    link_waddr  = slot_r;
    link_wdata  = head_r;
    link_re     = 1'b0;
    link_raddr  = cur;
    elem_we     = 1'b0;
    elem_waddr  = slot_r;
    elem_wdata  = in_val_dw;
    elem_re     = 1'b0;
    elem_raddr  = cur;
    case (state_r)
      ple_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          pos_nxt     = in_position;
          val_nxt     = in_val_dw;
          status_nxt  = ple_pkg::STATUS_DONE;
          rval_nxt    = '0;
          found_nxt   = '0;
          node_nxt    = head_r;
          src_mem_nxt = 1'b0;
          scan_nxt    = '0;
          steps_nxt   = '0;
          case (in_cmd)
            ple_pkg::CMD_INSERT: begin
              if (ins_bad) begin
                status_nxt = ple_pkg::STATUS_MISS;
              end else if (full) begin
                status_nxt = ple_pkg::STATUS_FULL;
              end else begin
                pop_nxt = wm_r != count_r;
                if (wm_r != count_r) begin
                  slot_nxt   = fhead_r;
                  link_re    = 1'b1;
                  link_raddr = fhead_r;
                end else begin
                  slot_nxt = wm_r[IW-1:0];
                  wm_nxt   = wm_r + one_c;
                end
                elem_we    = 1'b1;
                elem_waddr = slot_nxt;
                elem_wdata = in_val_dw;
              end
            end
            ple_pkg::CMD_DELETE: begin
              if (pos_bad) begin
                status_nxt = ple_pkg::STATUS_MISS;
              end else if (in_position != {{(PW-1){1'b0}}, 1'b1}) begin
                steps_nxt = in_position - PW'(2);
              end
            end
            ple_pkg::CMD_READ: begin
              if (pos_bad) begin
                status_nxt = ple_pkg::STATUS_MISS;
              end else begin
                steps_nxt = in_position - PW'(1);
              end
            end
            ple_pkg::CMD_LOCATE: begin
              status_nxt = ple_pkg::STATUS_DONE;
            end
            ple_pkg::CMD_CLEAR: begin
              head_nxt  = '0;
              fhead_nxt = '0;
              wm_nxt    = '0;
              count_nxt = '0;
            end
            default: status_nxt = ple_pkg::STATUS_MISS;
          endcase
        end
      end
      ple_pkg::ST_INS_START: begin
        if (pop_r) begin
          fhead_nxt = link_rdata;
        end
        if (pos_one) begin
          link_we    = 1'b1;
          link_waddr = slot_r;
          link_wdata = head_r;
          head_nxt   = slot_r;
          count_nxt  = count_r + one_c;
        end else begin
          steps_nxt   = pos_r - PW'(2);
          node_nxt    = head_r;
          src_mem_nxt = 1'b0;
        end
      end
      ple_pkg::ST_WALK: begin
        link_re    = 1'b1;
        link_raddr = cur;
        if (walk_done) begin
          elem_re     = 1'b1;
          elem_raddr  = cur;
          node_nxt    = cur;
          src_mem_nxt = 1'b0;
        end else begin
          steps_nxt   = steps_r - PW'(1);
          src_mem_nxt = 1'b1;
        end
      end
      ple_pkg::ST_INS_FIX: begin
        link_we    = 1'b1;
        link_waddr = slot_r;
        link_wdata = link_rdata;
      end
      ple_pkg::ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = node_r;
        link_wdata = slot_r;
        count_nxt  = count_r + one_c;
      end
      ple_pkg::ST_DEL_P1: begin
        head_nxt = link_rdata;
        rval_nxt = elem_rdata;
        slot_nxt = node_r;
      end
      ple_pkg::ST_DEL_Q: begin
        slot_nxt   = link_rdata;
        link_re    = 1'b1;
        link_raddr = link_rdata;
        elem_re    = 1'b1;
        elem_raddr = link_rdata;
      end
      ple_pkg::ST_DEL_FIX: begin
        link_we    = 1'b1;
        link_waddr = node_r;
        link_wdata = link_rdata;
        rval_nxt   = elem_rdata;
      end
      ple_pkg::ST_DEL_FREE: begin
        link_we    = 1'b1;
        link_waddr = slot_r;
        link_wdata = fhead_r;
        fhead_nxt  = slot_r;
        count_nxt  = count_r - one_c;
      end
      ple_pkg::ST_READ: begin
        rval_nxt = elem_rdata;
      end
      ple_pkg::ST_SCAN: begin
        if (scan_hit) begin
          found_nxt = scan_r;
        end else if (scan_end) begin
          status_nxt = ple_pkg::STATUS_MISS;
        end else begin
          link_re     = 1'b1;
          link_raddr  = cur;
          elem_re     = 1'b1;
          elem_raddr  = cur;
          scan_nxt    = scan_r + one_c;
          src_mem_nxt = 1'b1;
        end
      end
      default: begin
        cmd_nxt = cmd_r;
      end
    endcase
  end

  // result register
  assign rext = {{VW{1'b0}}, rval_r};
  assign cext = {{PW{1'b0}}, count_r};
  assign fext = {{PW{1'b0}}, found_r};

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::ST_IDLE;
      head_r      <= '0;
      fhead_r     <= '0;
      wm_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fhead_r     <= fhead_nxt;
      wm_r        <= wm_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    node_r    <= node_nxt;
    src_mem_r <= src_mem_nxt;
    steps_r   <= steps_nxt;
    scan_r    <= scan_nxt;
    slot_r    <= slot_nxt;
    pop_r     <= pop_nxt;
    status_r  <= status_nxt;
    rval_r    <= rval_nxt;
    found_r   <= found_nxt;
    if (fin_load) begin
      out_status_r <= status_r;
      out_rval_r   <= rext[VW-1:0];
      out_found_r  <= fext[PW-1:0];
      out_len_r    <= cext[PW-1:0];
      out_empty_r  <= count_r == '0;
    end
  end

  assign in_stall           = state_r != ple_pkg::ST_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_value   = out_rval_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_len_r;
  assign out_is_empty       = out_empty_r;

endmodule

@@ sv/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = ple_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = ple_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/positional_list_engine_tb.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives insert, delete, read, locate and clear words into the list engine.
// A queue mirrors the ordered list to predict each result. Directed tests
// cover the edge positions, a full list, unknown commands and clear. They
// are followed by grow, shrink and mixed random traffic. Both handshakes
// idle and stall at random.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = ple_pkg::CAPACITY_DEF;
  localparam int CW           = ple_pkg::CMD_W;
  localparam int PW           = ple_pkg::POS_W;
  localparam int CMD_SPAN     = 1 << ple_pkg::CMD_W;
  localparam int POS_SPAN     = 1 << ple_pkg::POS_W;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 16;

  typedef struct packed {
    logic [ple_pkg::STATUS_W-1:0]       status;
    logic signed [ple_pkg::VALUE_W-1:0] value;
    logic [ple_pkg::POS_W-1:0]          found;
    logic [ple_pkg::POS_W-1:0]          length;
    logic                               empty;
  } list_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [ple_pkg::CMD_W-1:0]          in_cmd = ple_pkg::CMD_INSERT;
  logic [ple_pkg::POS_W-1:0]          in_position = '0;
  logic signed [ple_pkg::VALUE_W-1:0] in_value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [ple_pkg::STATUS_W-1:0]       out_status;
  logic signed [ple_pkg::VALUE_W-1:0] out_result_value;
  logic [ple_pkg::POS_W-1:0]          out_found_position;
  logic [ple_pkg::POS_W-1:0]          out_list_length;
  logic                               out_is_empty;

  logic signed [ple_pkg::VALUE_W-1:0] shadow_list[$];
  list_result_t                       pending_results[$];
  list_result_t                       oldest_result;
  int                                 error_count = 0;
  logic                               quiet_mode = 1'b0;
  int                                 stall_run = 0;
  int                                 stall_roll;

  positional_list_engine u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_value   (out_result_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length),
    .out_is_empty       (out_is_empty)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic list_result_t predict_list_op(
      input logic [ple_pkg::CMD_W-1:0] cmd,
      input logic [ple_pkg::POS_W-1:0] pos,
      input logic signed [ple_pkg::VALUE_W-1:0] val);
    list_result_t r;
    int len;
    int k;
    r = '0;
    r.status = ple_pkg::STATUS_DONE;
    len = shadow_list.size();
    case (cmd)
      ple_pkg::CMD_INSERT: begin
        if (pos == 0 || pos > len + 1) r.status = ple_pkg::STATUS_MISS;
        else if (len >= LIST_DEPTH) r.status = ple_pkg::STATUS_FULL;
        else shadow_list.insert(pos - 1, val);
      end
      ple_pkg::CMD_DELETE: begin
        if (pos == 0 || pos > len) begin
          r.status = ple_pkg::STATUS_MISS;
        end else begin
          r.value = shadow_list[pos - 1];
          shadow_list.delete(pos - 1);
        end
      end
      ple_pkg::CMD_READ: begin
        if (pos == 0 || pos > len) r.status = ple_pkg::STATUS_MISS;
        else r.value = shadow_list[pos - 1];
      end
      ple_pkg::CMD_LOCATE: begin
        for (k = 0; k < len && r.found == 0; k++)
          if (shadow_list[k] == val) r.found = PW'(k + 1);
        if (r.found == 0) r.status = ple_pkg::STATUS_MISS;
      end
      ple_pkg::CMD_CLEAR: shadow_list.delete();
      default: r.status = ple_pkg::STATUS_MISS;
    endcase
    r.length = PW'(shadow_list.size());
    r.empty  = (shadow_list.size() == 0);
    return r;
  endfunction

  function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
    logic signed [ple_pkg::VALUE_W-1:0] v;
    // small values give duplicates for locate
    if ($urandom_range(0, 2) == 0) v = $urandom_range(0, 7);
    else v = $urandom;
    return v;
  endfunction

  task automatic send_word(input logic [ple_pkg::CMD_W-1:0] cmd,
                           input logic [ple_pkg::POS_W-1:0] pos,
                           input logic signed [ple_pkg::VALUE_W-1:0] val);
    int gap;
    int roll;
    gap = 0;
    roll = $urandom_range(0, 99);
    if (!quiet_mode) begin
      if (roll >= 92) gap = $urandom_range(10, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd      <= cmd;
    in_position <= pos;
    in_value    <= val;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_list_op(cmd, pos, val));
  endtask

  task automatic wait_results_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result stall: mostly short, a few long
  always @(negedge clk) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 95) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(9, 39);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result word with nothing pending");
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status)
          report_error($sformatf("status %0d, expected %0d", out_status,
                                 oldest_result.status));
        if (out_result_value !== oldest_result.value)
          report_error($sformatf("result_value %0d, expected %0d", out_result_value,
                                 oldest_result.value));
        if (out_found_position !== oldest_result.found)
          report_error($sformatf("found_position %0d, expected %0d", out_found_position,
                                 oldest_result.found));
        if (out_list_length !== oldest_result.length)
          report_error($sformatf("list_length %0d, expected %0d", out_list_length,
                                 oldest_result.length));
        if (out_is_empty !== oldest_result.empty)
          report_error($sformatf("is_empty %0b, expected %0b", out_is_empty,
                                 oldest_result.empty));
      end
    end
  end

  task automatic test_insert_edges();
    send_word(ple_pkg::CMD_INSERT, 0, 32'sd5);
    send_word(ple_pkg::CMD_INSERT, 2, 32'sd5);
    send_word(ple_pkg::CMD_INSERT, PW'(POS_SPAN - 1), 32'sd5);
    send_word(ple_pkg::CMD_INSERT, 1, 32'sh7fffffff);
    send_word(ple_pkg::CMD_INSERT, 2, 32'sh80000000);
    send_word(ple_pkg::CMD_INSERT, 1, 32'sd0);
    send_word(ple_pkg::CMD_INSERT, 4, -32'sd1);
  endtask

  task automatic test_read_delete_edges();
    send_word(ple_pkg::CMD_READ, 0, 32'sd0);
    send_word(ple_pkg::CMD_READ, 4, 32'sd0);
    send_word(ple_pkg::CMD_READ, 5, 32'sd0);
    send_word(ple_pkg::CMD_READ, PW'(POS_SPAN - 1), 32'sd0);
    send_word(ple_pkg::CMD_DELETE, 0, 32'sd0);
    send_word(ple_pkg::CMD_DELETE, 5, 32'sd0);
    send_word(ple_pkg::CMD_DELETE, 2, 32'sd0);
    send_word(ple_pkg::CMD_DELETE, 3, 32'sd0);
  endtask

  task automatic test_locate();
    send_word(ple_pkg::CMD_LOCATE, 0, 32'sh80000000);
    send_word(ple_pkg::CMD_LOCATE, 0, 32'sd12345);
    send_word(ple_pkg::CMD_LOCATE, PW'(POS_SPAN - 1), 32'sd0);
  endtask

  task automatic test_unknown_commands();
    int c;
    for (c = ple_pkg::CMD_CLEAR + 1; c < CMD_SPAN; c++)
      send_word(CW'(c), PW'($urandom_range(0, POS_SPAN - 1)), $urandom);
  endtask

  task automatic test_clear();
    send_word(ple_pkg::CMD_CLEAR, 0, 32'sd0);
    send_word(ple_pkg::CMD_READ, 1, 32'sd0);
    send_word(ple_pkg::CMD_DELETE, 1, 32'sd0);
    send_word(ple_pkg::CMD_LOCATE, 0, 32'sd0);
    send_word(ple_pkg::CMD_CLEAR, PW'(POS_SPAN - 1), -32'sd1);
  endtask

  task automatic test_full_list();
    quiet_mode = 1'b1;
    while (shadow_list.size() < LIST_DEPTH) begin
      if (shadow_list.size() == LIST_DEPTH / 2) quiet_mode = 1'b0;
      send_word(ple_pkg::CMD_INSERT, PW'($urandom_range(1, shadow_list.size() + 1)),
                pick_value());
    end
    send_word(ple_pkg::CMD_INSERT, 1, pick_value());
    send_word(ple_pkg::CMD_INSERT, PW'(LIST_DEPTH + 1), pick_value());
    send_word(ple_pkg::CMD_INSERT, PW'(LIST_DEPTH + 2), pick_value());
    send_word(ple_pkg::CMD_READ, PW'(LIST_DEPTH), 32'sd0);
    send_word(ple_pkg::CMD_LOCATE, 0, shadow_list[LIST_DEPTH - 1]);
    send_word(ple_pkg::CMD_DELETE, PW'(LIST_DEPTH), 32'sd0);
    send_word(ple_pkg::CMD_INSERT, PW'(LIST_DEPTH), pick_value());
    wait_results_idle();
  endtask

  task automatic test_random_traffic();
    int round;
    int n;
    int roll;
    int len;
    int ins_pct;
    int del_pct;
    logic [ple_pkg::CMD_W-1:0]          cmd;
    logic [ple_pkg::POS_W-1:0]          pos;
    logic signed [ple_pkg::VALUE_W-1:0] val;
    for (round = 0; round < 11; round++) begin
      quiet_mode = (round % 4 == 2);
      case (round % 3)
        0: begin
          ins_pct = 75;
          del_pct = 5;
        end
        1: begin
          ins_pct = 15;
          del_pct = 50;
        end
        default: begin
          ins_pct = 35;
          del_pct = 30;
        end
      endcase
      for (n = 0; n < 50; n++) begin
        len  = shadow_list.size();
        roll = $urandom_range(0, 99);
        pos  = PW'($urandom_range(0, POS_SPAN - 1));
        val  = pick_value();
        if (roll < 8) begin
          cmd = CW'($urandom_range(0, CMD_SPAN - 1));
          val = $urandom;
        end else if (roll < 9) begin
          cmd = ple_pkg::CMD_CLEAR;
        end else if (roll < 9 + ins_pct) begin
          cmd = ple_pkg::CMD_INSERT;
          pos = PW'($urandom_range(1, len + 1));
        end else if (roll < 9 + ins_pct + del_pct && len != 0) begin
          cmd = ple_pkg::CMD_DELETE;
          pos = PW'($urandom_range(1, len));
        end else if (roll % 2 == 0 && len != 0) begin
          cmd = ple_pkg::CMD_READ;
          pos = PW'($urandom_range(1, len));
        end else begin
          cmd = ple_pkg::CMD_LOCATE;
          if (len != 0 && $urandom_range(0, 3) != 0)
            val = shadow_list[$urandom_range(0, len - 1)];
        end
        send_word(cmd, pos, val);
      end
      if (round % 5 == 4) wait_results_idle();
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_insert_edges();
    test_read_delete_edges();
    test_locate();
    test_unknown_commands();
    test_clear();
    test_full_list();
    test_random_traffic();
    wait_results_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ positional_list_engine.f @@
sv/ple_pkg.sv
sv/ple_ram.sv
sv/positional_list_engine.sv
tb/positional_list_engine_tb.sv
